// ===== hdl/tga_rle_pixel_decoder_top_macros.svh =====
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder assertion macros
// Shared concurrent assertion forms on clk with asynchronous reset arst_n.
// ----------------------------------------------------------------------------
`ifndef TGA_RLE_PIXEL_DECODER_TOP_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_TOP_MACROS_SVH

// Check a property at every clock edge outside reset
`define TRPD_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that an antecedent leads to a consequent in the next cycle
`define TRPD_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/trpd_pkg.sv =====
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder package
// Types and fixed codes shared by the decoder and its checker.
// ----------------------------------------------------------------------------
package trpd_pkg;

	// Pixel format codes
	localparam logic [1:0] FMT_16 = 2'd0;
	localparam logic [1:0] FMT_24 = 2'd1;
	localparam logic [1:0] FMT_32 = 2'd2;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_COMPRESSED = 2'd0;
	localparam logic [1:0] REG_FORMAT     = 2'd1;
	localparam logic [1:0] REG_WIDTH      = 2'd2;
	localparam logic [1:0] REG_HEIGHT     = 2'd3;

	// Packet header fields
	localparam int unsigned REPEAT_BIT = 7;
	localparam logic [6:0]  COUNT_MASK = 7'h7F;
	localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;
	localparam logic [3:0]  MIN_WIDTH_LOG2 = 4'd2;

	// Longest segment a single pixel can cause
	localparam int unsigned MAX_RUN = 128;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pixel_t;

endpackage

// ===== hdl/tga_rle_pixel_decoder_top.sv =====
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder
// Turns TGA image-data bytes into pixel runs per output row, rows flipped.
// ----------------------------------------------------------------------------
//  channel  handshake                 payload
//  in       in_valid / in_ready       data_byte
//  out      out_valid / out_ready     red green blue alpha column row
//                                     run_length last_segment image_done
//  cfg      psel penable pwrite pready paddr pwdata prdata
//
//  A byte is taken into an input register, then decoded and its first row
//  segment written to the output register: one byte per cycle while no split
//  run is pending and the output can take a segment. A repeat run that crosses
//  rows is split into further segments (up to 32 more at the narrowest width).
//  Reset or any register write restarts decoding at the first pixel; a stalled
//  output holds the current segment and stops any further segment behind it.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_top #(
	parameter int MAX_SIDE_LOG2 = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	// input byte channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	// output segment channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic [11:0] column,
	output logic [11:0] row,
	output logic [7:0]  run_length,
	output logic        last_segment,
	output logic        image_done,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import trpd_pkg::*;

	localparam int AW = (MAX_SIDE_LOG2 + 1 > 12) ? MAX_SIDE_LOG2 + 1 : 12;
	localparam logic [3:0] MAX_LOG2 = 4'(MAX_SIDE_LOG2);

	// configuration registers
	logic       compressed_q;
	logic [1:0] pixel_format_q;
	logic [3:0] width_log2_q;
	logic [3:0] height_log2_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// decode state
	logic [7:0]               raw_remaining_q;
	logic                     repeat_pending_q;
	logic [7:0]               repeat_count_q;
	logic [1:0]               byte_phase_q;
	logic [23:0]              pixel_bytes_q;
	logic [MAX_SIDE_LOG2-1:0] column_pos_q;
	logic [MAX_SIDE_LOG2:0]   file_row_q;
	logic                     finished_q;

	// pending split run
	logic       run_active_q;
	logic [7:0] run_cnt_q;
	pixel_t     run_pix_q;

	// output register
	logic        out_valid_q;
	pixel_t      out_pix_q;
	logic [11:0] out_col_q;
	logic [11:0] out_row_q;
	logic [7:0]  out_len_q;
	logic        out_last_q;
	logic        out_done_q;

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	// register read back
	always_comb begin
		case (paddr[3:2])
			REG_COMPRESSED: prdata = {31'd0, compressed_q};
			REG_FORMAT:     prdata = {30'd0, pixel_format_q};
			REG_WIDTH:      prdata = {28'd0, width_log2_q};
			REG_HEIGHT:     prdata = {28'd0, height_log2_q};
			default:        prdata = 32'd0;
		endcase
	end

	// classify the byte in the input register
	logic       is_header;
	logic [2:0] nbytes;
	logic       pix_done;
	logic       need_out;
	logic       out_free;
	logic       consume;

	always_comb begin
		case (pixel_format_q)
			FMT_16:  nbytes = 3'd2;
			FMT_24:  nbytes = 3'd3;
			default: nbytes = 3'd4;
		endcase
	end

	assign is_header = compressed_q && (raw_remaining_q == 8'd0) && !repeat_pending_q;
	assign pix_done  = !is_header && ({1'b0, byte_phase_q} + 3'd1 >= nbytes);
	assign need_out  = pix_done && !finished_q;
	assign out_free  = !out_valid_q || out_ready;
	assign consume   = valid_s1 && !run_active_q && (out_free || !need_out);
	assign in_ready  = !valid_s1 || consume;

	// assemble the finished pixel
	pixel_t new_pix;
	always_comb begin
		logic [15:0] c16;
		c16 = {byte_s1, pixel_bytes_q[7:0]};
		case (pixel_format_q)
			FMT_16: begin
				new_pix.red   = {c16[14:10], 3'b000};
				new_pix.green = {c16[9:5], 3'b000};
				new_pix.blue  = {c16[4:0], 3'b000};
				new_pix.alpha = ALPHA_OPAQUE;
			end
			FMT_24: begin
				new_pix.red   = byte_s1;
				new_pix.green = pixel_bytes_q[15:8];
				new_pix.blue  = pixel_bytes_q[7:0];
				new_pix.alpha = ALPHA_OPAQUE;
			end
			default: begin
				new_pix.red   = pixel_bytes_q[23:16];
				new_pix.green = pixel_bytes_q[15:8];
				new_pix.blue  = pixel_bytes_q[7:0];
				new_pix.alpha = byte_s1;
			end
		endcase
	end

	// select the segment source: split run or fresh pixel
	pixel_t     src_pix;
	logic [7:0] src_cnt;
	logic       go;
	assign src_pix = run_active_q ? run_pix_q : new_pix;
	assign src_cnt = run_active_q ? run_cnt_q : (repeat_pending_q ? repeat_count_q : 8'd1);
	assign go      = run_active_q ? out_free : (consume && need_out);

	// clamp image size
	logic [3:0] wl;
	logic [3:0] hl;
	always_comb begin
		wl = width_log2_q;
		if (wl < MIN_WIDTH_LOG2) wl = MIN_WIDTH_LOG2;
		if (wl > MAX_LOG2) wl = MAX_LOG2;
		hl = (height_log2_q > MAX_LOG2) ? MAX_LOG2 : height_log2_q;
	end

	// cut one segment at the row end
	logic [AW-1:0] width_a, height_a, col_a, room_a, cnt_a, seg_a, next_col_a, row_a;
	logic          row_end, done_now;
	logic [7:0]    rem;
	assign width_a    = AW'(1) << wl;
	assign height_a   = AW'(1) << hl;
	assign col_a      = AW'(column_pos_q);
	assign room_a     = width_a - col_a;
	assign cnt_a      = AW'(src_cnt);
	assign seg_a      = (cnt_a < room_a) ? cnt_a : room_a;
	assign next_col_a = col_a + seg_a;
	assign row_end    = (next_col_a == width_a);
	assign done_now   = row_end && (AW'(file_row_q) + AW'(1) == height_a);
	assign row_a      = height_a - AW'(1) - AW'(file_row_q);
	assign rem        = src_cnt - seg_a[7:0];

	// control state, configuration and decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compressed_q     <= 1'b1;
			pixel_format_q   <= FMT_32;
			width_log2_q     <= 4'd8;
			height_log2_q    <= 4'd8;
			valid_s1         <= 1'b0;
			raw_remaining_q  <= 8'd0;
			repeat_pending_q <= 1'b0;
			repeat_count_q   <= 8'd0;
			byte_phase_q     <= 2'd0;
			pixel_bytes_q    <= 24'd0;
			column_pos_q     <= '0;
			file_row_q       <= '0;
			finished_q       <= 1'b0;
			run_active_q     <= 1'b0;
			run_cnt_q        <= 8'd0;
			out_valid_q      <= 1'b0;
		end else begin
			// advance the input register
			if (in_valid && in_ready) valid_s1 <= 1'b1;
			else if (consume) valid_s1 <= 1'b0;

			// advance the output register
			if (go) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			if (cfg_wr) begin
				// write a register and restart decoding
				case (paddr[3:2])
					REG_COMPRESSED: compressed_q   <= pwdata[0];
					REG_FORMAT:     pixel_format_q <= pwdata[1:0];
					REG_WIDTH:      width_log2_q   <= pwdata[3:0];
					REG_HEIGHT:     height_log2_q  <= pwdata[3:0];
					default:        compressed_q   <= compressed_q;
				endcase
				raw_remaining_q  <= 8'd0;
				repeat_pending_q <= 1'b0;
				repeat_count_q   <= 8'd0;
				byte_phase_q     <= 2'd0;
				pixel_bytes_q    <= 24'd0;
				column_pos_q     <= '0;
				file_row_q       <= '0;
				finished_q       <= 1'b0;
				run_active_q     <= 1'b0;
				run_cnt_q        <= 8'd0;
			end else begin
				// decode the byte unless the image is full
				if (consume && !finished_q) begin
					if (is_header) begin
						if (byte_s1[REPEAT_BIT]) begin
							repeat_pending_q <= 1'b1;
							repeat_count_q   <= {1'b0, byte_s1[6:0] & COUNT_MASK} + 8'd1;
						end else begin
							raw_remaining_q  <= {1'b0, byte_s1[6:0] & COUNT_MASK} + 8'd1;
						end
						byte_phase_q  <= 2'd0;
						pixel_bytes_q <= 24'd0;
					end else if (!pix_done) begin
						case (byte_phase_q)
							2'd0:    pixel_bytes_q[7:0]   <= byte_s1;
							2'd1:    pixel_bytes_q[15:8]  <= byte_s1;
							default: pixel_bytes_q[23:16] <= byte_s1;
						endcase
						byte_phase_q <= byte_phase_q + 2'd1;
					end else begin
						byte_phase_q  <= 2'd0;
						pixel_bytes_q <= 24'd0;
						if (repeat_pending_q) begin
							repeat_pending_q <= 1'b0;
							repeat_count_q   <= 8'd0;
						end else if (compressed_q && raw_remaining_q != 8'd0) begin
							raw_remaining_q <= raw_remaining_q - 8'd1;
						end
					end
				end

				// step the position and keep any remainder of the run
				if (go) begin
					if (row_end) begin
						column_pos_q <= '0;
						file_row_q   <= file_row_q + (MAX_SIDE_LOG2 + 1)'(1);
					end else begin
						column_pos_q <= next_col_a[MAX_SIDE_LOG2-1:0];
					end
					if (done_now) finished_q <= 1'b1;
					run_active_q <= (rem != 8'd0) && !done_now;
					run_cnt_q    <= rem;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) byte_s1 <= data_byte;
		if (go) begin
			run_pix_q  <= src_pix;
			out_pix_q  <= src_pix;
			out_col_q  <= col_a[11:0];
			out_row_q  <= row_a[11:0];
			out_len_q  <= seg_a[7:0];
			out_last_q <= (rem == 8'd0) || done_now;
			out_done_q <= done_now;
		end
	end

	assign out_valid    = out_valid_q;
	assign red          = out_pix_q.red;
	assign green        = out_pix_q.green;
	assign blue         = out_pix_q.blue;
	assign alpha        = out_pix_q.alpha;
	assign column       = out_col_q;
	assign row          = out_row_q;
	assign run_length   = out_len_q;
	assign last_segment = out_last_q;
	assign image_done   = out_done_q;

endmodule

// ===== hdl/trpd_checker.sv =====
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder checker
// Port-level assertions on the segment channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "tga_rle_pixel_decoder_top_macros.svh"

module trpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [11:0] column,
	input logic [11:0] row,
	input logic [7:0]  run_length,
	input logic        last_segment,
	input logic        image_done
);
	import trpd_pkg::*;

	// hold a stalled beat
	`TRPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(column) && $stable(row) && $stable(run_length), "stalled segment beat changed")

	// keep the segment length within one packet
	`TRPD_ASSERT(a_len_range, !out_valid || (run_length != 8'd0 && 32'(run_length) <= MAX_RUN), "segment length out of range")

	// mark the last segment of the run on the segment that fills the image
	`TRPD_ASSERT(a_done_last, !(out_valid && image_done) || last_segment, "image end not on last segment")

	// drop everything once the image is full
	`TRPD_ASSERT_NEXT(a_quiet_after_done, out_valid && out_ready && image_done, !out_valid, "segment after image end")

endmodule

bind tga_rle_pixel_decoder_top trpd_checker u_trpd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.column       (column),
	.row          (row),
	.run_length   (run_length),
	.last_segment (last_segment),
	.image_done   (image_done)
);

// ===== dv/tga_rle_pixel_decoder_top_test.sv =====
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder testbench
// Feeds image-data bytes through the byte channel under random bursts and
// output stalls, and predicts every row segment from its own copy of the
// decoder state. Each segment is checked field by field in order.
// Register settings are changed only while the decoder is idle.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_top_test;
	import trpd_pkg::*;

	localparam int          MAX_SIDE_LOG2 = 12;
	localparam logic [1:0]  FMT_UNUSED = 2'd3;
	localparam int unsigned SETTLE_CYCLES = 60;
	localparam int unsigned CYCLE_LIMIT = 1000000;

	typedef struct {
		pixel_t      color;
		logic [11:0] column;
		logic [11:0] row;
		logic [7:0]  run_length;
		logic        last_segment;
		logic        image_done;
	} segment_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic [11:0] column;
	logic [11:0] row;
	logic [7:0]  run_length;
	logic        last_segment;
	logic        image_done;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = 4'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	// Register copy, reset values
	logic        cfg_compressed = 1'b1;
	logic [1:0]  cfg_format = FMT_32;
	logic [3:0]  cfg_width_log2 = 4'd8;
	logic [3:0]  cfg_height_log2 = 4'd8;

	// Decoder state copy
	int unsigned raw_left = 0;
	logic        repeat_armed = 1'b0;
	int unsigned repeat_len = 0;
	int unsigned pix_phase = 0;
	logic [23:0] gathered = '0;
	int unsigned col_pos = 0;
	int unsigned row_pos = 0;
	logic        image_full = 1'b0;

	segment_t    segments_due[$];
	int unsigned errors = 0;
	int unsigned cycle_count = 0;
	int unsigned live_items = 0;
	int unsigned burst_left = 0;
	int unsigned tx_gap_pct = 0;
	int unsigned rx_stall_pct = 0;
	int unsigned stall_left = 0;

	tga_rle_pixel_decoder_top #(
		.MAX_SIDE_LOG2(MAX_SIDE_LOG2)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha),
		.column(column),
		.row(row),
		.run_length(run_length),
		.last_segment(last_segment),
		.image_done(image_done),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned bytes_per_pixel(input logic [1:0] fmt);
		case (fmt)
			FMT_16: return 2;
			FMT_24: return 3;
			default: return 4;
		endcase
	endfunction

	function automatic int unsigned clamp_log2(input logic [3:0] v, input int unsigned lo);
		int unsigned x;
		x = v;
		if (x < lo) x = lo;
		if (x > MAX_SIDE_LOG2) x = MAX_SIDE_LOG2;
		return x;
	endfunction

	// Advance the decoder copy by one byte and queue the segments it yields
	function automatic void decode_byte(input logic [7:0] b);
		int unsigned size, count, width, height, room, seg;
		logic [15:0] word;
		pixel_t      px;
		segment_t    s;
		if (image_full) return;
		if (cfg_compressed && raw_left == 0 && !repeat_armed) begin
			if (b[REPEAT_BIT]) begin
				repeat_armed = 1'b1;
				repeat_len = int'(b[6:0] & COUNT_MASK) + 1;
			end else begin
				raw_left = int'(b[6:0] & COUNT_MASK) + 1;
			end
			pix_phase = 0;
			gathered = '0;
			return;
		end
		size = bytes_per_pixel(cfg_format);
		if (pix_phase + 1 < size) begin
			gathered = gathered | (24'(b) << (8 * pix_phase));
			pix_phase++;
			return;
		end
		case (size)
			2: begin
				word = {b, gathered[7:0]};
				px.red = {word[14:10], 3'b000};
				px.green = {word[9:5], 3'b000};
				px.blue = {word[4:0], 3'b000};
				px.alpha = ALPHA_OPAQUE;
			end
			3: begin
				px.red = b;
				px.green = gathered[15:8];
				px.blue = gathered[7:0];
				px.alpha = ALPHA_OPAQUE;
			end
			default: begin
				px.red = gathered[23:16];
				px.green = gathered[15:8];
				px.blue = gathered[7:0];
				px.alpha = b;
			end
		endcase
		pix_phase = 0;
		gathered = '0;
		if (repeat_armed) begin
			count = repeat_len;
			repeat_armed = 1'b0;
			repeat_len = 0;
		end else begin
			count = 1;
			if (cfg_compressed && raw_left > 0) raw_left--;
		end
		width = 1 << clamp_log2(cfg_width_log2, MIN_WIDTH_LOG2);
		height = 1 << clamp_log2(cfg_height_log2, 0);
		// Split the run at row ends, drop whatever lies past the image
		while (count > 0 && !image_full) begin
			room = width - col_pos;
			seg = (count < room) ? count : room;
			s.color = px;
			s.column = col_pos[11:0];
			s.row = 12'(height - 1 - row_pos);
			s.run_length = 8'(seg);
			s.image_done = 1'b0;
			col_pos += seg;
			count -= seg;
			if (col_pos >= width) begin
				col_pos = 0;
				row_pos++;
				if (row_pos >= height) begin
					image_full = 1'b1;
					s.image_done = 1'b1;
				end
			end
			s.last_segment = (count == 0) || image_full;
			segments_due.push_back(s);
		end
	endfunction

	function automatic void check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, what, want, got);
			errors++;
		end
	endfunction

	// Check each output beat against the oldest expectation, then pick the
	// next ready level from the stall pattern
	always @(posedge clk) begin
		segment_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d segments outstanding", $time, segments_due.size());
			$display("== FAIL ==");
			$finish;
		end else begin
			if (arst_n && out_valid && out_ready) begin
				if (segments_due.size() == 0) begin
					$display("%0t: segment with nothing expected, expected none actual col %0d row %0d",
						$time, column, row);
					errors++;
				end else begin
					want = segments_due.pop_front();
					check_field("red", want.color.red, red);
					check_field("green", want.color.green, green);
					check_field("blue", want.color.blue, blue);
					check_field("alpha", want.color.alpha, alpha);
					check_field("column", want.column, column);
					check_field("row", want.row, row);
					check_field("run_length", want.run_length, run_length);
					check_field("last_segment", want.last_segment, last_segment);
					check_field("image_done", want.image_done, image_done);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 99) < rx_stall_pct) stall_left = $urandom_range(1, 8);
			end
		end
	end

	// Send one byte beat, opening a gap between bursts now and then
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 99) < tx_gap_pct) gap = $urandom_range(1, 6);
		end
		burst_left--;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
		if (!image_full) live_items++;
		decode_byte(b);
	endtask

	task automatic send_random_pixel();
		repeat (bytes_per_pixel(cfg_format)) send_byte(8'($urandom_range(0, 255)));
	endtask

	// Drop valid and hold until every expected segment has come out
	task automatic hold_for_results();
		in_valid <= 1'b0;
		while (segments_due.size() != 0) @(posedge clk);
	endtask

	// Hold until idle, then let any byte still inside the decoder drain
	task automatic settle();
		hold_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register; any write restarts decoding at the first pixel
	task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_COMPRESSED: cfg_compressed = value[0];
			REG_FORMAT: cfg_format = value[1:0];
			REG_WIDTH: cfg_width_log2 = value[3:0];
			REG_HEIGHT: cfg_height_log2 = value[3:0];
			default: ;
		endcase
		raw_left = 0;
		repeat_armed = 1'b0;
		repeat_len = 0;
		pix_phase = 0;
		gathered = '0;
		col_pos = 0;
		row_pos = 0;
		image_full = 1'b0;
	endtask

	task automatic configure(input logic comp, input logic [1:0] fmt,
			input logic [3:0] wl, input logic [3:0] hl);
		write_register(REG_COMPRESSED, 32'(comp));
		write_register(REG_FORMAT, 32'(fmt));
		write_register(REG_WIDTH, 32'(wl));
		write_register(REG_HEIGHT, 32'(hl));
	endtask

	task automatic pick_idling();
		case ($urandom_range(0, 2))
			0: tx_gap_pct = 0;
			1: tx_gap_pct = 15;
			default: tx_gap_pct = 50;
		endcase
		case ($urandom_range(0, 2))
			0: rx_stall_pct = 0;
			1: rx_stall_pct = 15;
			default: rx_stall_pct = 50;
		endcase
	endtask

	// Mostly well-formed packets with random pixels, a little stray noise
	task automatic send_stream(input int unsigned n, input int unsigned lo,
			input int unsigned hi, input int unsigned repeat_pct);
		int unsigned start, count;
		start = live_items;
		while (live_items - start < n && !image_full) begin
			if ($urandom_range(0, 99) < 5) begin
				send_byte(8'($urandom_range(0, 255)));
			end else if (!cfg_compressed) begin
				send_random_pixel();
			end else if ($urandom_range(0, 99) < repeat_pct) begin
				count = $urandom_range(lo, hi);
				send_byte({1'b1, 7'(count - 1)});
				send_random_pixel();
			end else begin
				count = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
				send_byte({1'b0, 7'(count - 1)});
				repeat (count) send_random_pixel();
			end
			if ($urandom_range(0, 49) == 0) hold_for_results();
		end
	endtask

	// Default settings: 32-bit pixels on a 256 by 256 image
	task automatic test_reset_values();
		tx_gap_pct = 20;
		rx_stall_pct = 20;
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		settle();
	endtask

	// Narrowest row, clamped up from zero: a full repeat splits into 33 segments
	task automatic test_row_split();
		configure(1'b1, FMT_16, 4'd0, 4'd6);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		settle();
	endtask

	// Plain pixels on the largest image, sizes clamped down, then the unused format
	task automatic test_plain_formats();
		configure(1'b0, FMT_24, 4'd15, 4'd15);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h80);
		settle();
		write_register(REG_FORMAT, 32'(FMT_UNUSED));
		send_byte(8'h12);
		send_byte(8'h34);
		send_byte(8'h56);
		send_byte(8'h78);
		settle();
	endtask

	// One-row image: a repeat overflows it, and later bytes are ignored
	task automatic test_image_end();
		configure(1'b1, FMT_UNUSED, 4'd2, 4'd0);
		send_byte(8'hFF);
		repeat (4) send_byte(8'($urandom_range(0, 255)));
		send_byte(8'h00);
		send_byte(8'hA5);
		settle();
	endtask

	// A write in the middle of a packet drops the partial pixel and header
	task automatic test_restart_on_write();
		write_register(REG_HEIGHT, 32'd3);
		send_byte(8'h81);
		send_byte(8'h11);
		send_byte(8'h22);
		settle();
		write_register(REG_FORMAT, 32'(FMT_16));
		send_byte(8'h00);
		send_byte(8'hAA);
		send_byte(8'h55);
		settle();
	endtask

	// Long repeats across the widest row reach the high column values
	task automatic test_widest_row();
		configure(1'b1, FMT_16, 4'd12, 4'($urandom_range(0, 12)));
		pick_idling();
		send_stream(60, 96, 128, 100);
		settle();
	endtask

	// Random settings per phase, small images most of the time
	task automatic test_random_streams();
		int unsigned goal, roll;
		logic [3:0]  wl, hl;
		goal = live_items + 380;
		while (live_items < goal) begin
			roll = $urandom_range(0, 9);
			wl = (roll < 6) ? 4'($urandom_range(0, 4)) :
				(roll < 9) ? 4'($urandom_range(5, 9)) : 4'($urandom_range(10, 15));
			roll = $urandom_range(0, 9);
			hl = (roll < 5) ? 4'($urandom_range(0, 3)) :
				(roll < 8) ? 4'($urandom_range(4, 8)) : 4'($urandom_range(9, 15));
			configure($urandom_range(0, 3) != 0, 2'($urandom_range(0, 3)), wl, hl);
			pick_idling();
			send_stream($urandom_range(20, 60), 1, 128, 50);
			settle();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_row_split();
		test_plain_formats();
		test_image_end();
		test_restart_on_write();
		test_widest_row();
		test_random_streams();
		settle();
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
